// ===== design/pgm_pkg.sv =====
package pgm_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int IDX_W     = $clog2(MAX_WIDTH);
    localparam int PIXEL_W   = 8;
    localparam int SUM_W     = PIXEL_W + 1;
    localparam int MAG_W     = 10;
    localparam int LW_W      = 11;

    localparam logic [LW_W-1:0]    LINE_WIDTH_RESET = LW_W'(640);
    localparam logic [PIXEL_W-1:0] VERT_CLAMP       = PIXEL_W'(255);
    localparam logic [MAG_W-1:0]   MAG_MAX          = MAG_W'(573);

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

    function automatic logic [IDX_W-1:0] load_index(input logic [LW_W-1:0] width);
        logic [IDX_W-1:0] idx;
        if (width == '0) begin
            idx = '0;
        end else if (int'(width) > MAX_WIDTH) begin
            idx = IDX_W'(MAX_WIDTH - 1);
        end else begin
            idx = IDX_W'(int'(width) - 1);
        end
        return idx;
    endfunction

endpackage

// ===== design/pgm_cell.sv =====
module pgm_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pgm_pkg::t_cell_ctrl           i_ctrl,
    input  logic                          i_load,
    input  logic [pgm_pkg::PIXEL_W-1:0]   i_pixel,
    input  logic [pgm_pkg::PIXEL_W-1:0]   i_next,
    output logic [pgm_pkg::PIXEL_W-1:0]   o_data
);
    import pgm_pkg::*;

    logic [PIXEL_W-1:0] r_data;
    logic [PIXEL_W-1:0] n_data;

    // insert point takes the new pixel, every other cell takes its upstream neighbor
    always_comb begin
        n_data = r_data;
        if (i_ctrl.clear) begin
            n_data = '0;
        end else if (i_ctrl.shift) begin
            n_data = i_load ? i_pixel : i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

// ===== design/pgm_grad.sv =====
module pgm_grad (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [pgm_pkg::PIXEL_W-1:0]   i_pixel,
    input  logic [pgm_pkg::PIXEL_W-1:0]   i_above,
    input  logic                          i_stall,
    output logic                          o_stall,
    output logic                          o_accept,
    output logic                          o_valid,
    output logic [pgm_pkg::MAG_W-1:0]     o_magnitude
);
    import pgm_pkg::*;

    logic               advance;
    logic               accept;
    logic [PIXEL_W-1:0] vcur;
    logic [SUM_W-1:0]   vsum;
    logic [PIXEL_W-1:0] gv;
    logic [SUM_W-1:0]   s;
    logic [SUM_W-1:0]   gh;
    logic [MAG_W-1:0]   tsum;
    logic [MAG_W+1:0]   tri3;
    logic [MAG_W-1:0]   scaled;
    logic [MAG_W-1:0]   mag;

    logic [PIXEL_W-1:0] r_prev_v;
    logic [SUM_W-1:0]   r_prev_s;
    logic               r_s1_valid;
    logic [PIXEL_W-1:0] r_s1_gv;
    logic [SUM_W-1:0]   r_s1_gh;
    logic               r_out_valid;
    logic [MAG_W-1:0]   r_out_mag;

    assign advance  = !r_out_valid || !i_stall;
    assign accept   = i_valid && advance;
    assign o_stall  = !advance;
    assign o_accept = accept;

    always_comb begin
        vcur = (i_above >= i_pixel) ? (i_above - i_pixel) : (i_pixel - i_above);
        vsum = {1'b0, r_prev_v} + {1'b0, vcur};
        gv   = (vsum > {1'b0, VERT_CLAMP}) ? VERT_CLAMP : vsum[PIXEL_W-1:0];
        s    = {1'b0, i_above} + {1'b0, i_pixel};
        gh   = (r_prev_s >= s) ? (r_prev_s - s) : (s - r_prev_s);
    end

    // max(v,h,(3*(v+h))>>2)
    always_comb begin
        tsum   = MAG_W'(r_s1_gv) + MAG_W'(r_s1_gh);
        tri3   = (MAG_W+2)'(tsum) + {1'b0, tsum, 1'b0};
        scaled = tri3[MAG_W+1:2];
        mag    = MAG_W'(r_s1_gv);
        if (MAG_W'(r_s1_gh) > mag) begin
            mag = MAG_W'(r_s1_gh);
        end
        if (scaled > mag) begin
            mag = scaled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_v    <= '0;
            r_prev_s    <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_prev_v <= vcur;
                r_prev_s <= s;
            end
            if (advance) begin
                r_s1_valid  <= accept;
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_gv   <= gv;
            r_s1_gh   <= gh;
            r_out_mag <= mag;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_magnitude = r_out_mag;

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted request did not reach stage one");

    a_s1_moves_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && advance |=> r_out_valid)
        else $error("stage one result lost");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |=> r_out_valid && $stable(r_out_mag))
        else $error("stalled result dropped or changed");

    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_mag <= MAG_MAX)
        else $error("magnitude out of range");

endmodule

// ===== design/pixel_gradient_magnitude.sv =====
// Channel   Direction  Handshake            Payload
// pixel     in         i_valid / o_stall    i_pixel[7:0]
// result    out        o_valid / i_stall    o_magnitude[9:0]
// config    in         i_cfg_we             i_cfg_data[10:0] (line width)
//
// One pixel per cycle sustained unless o_stall; results pass r_s1, then r_out.
// The row above lives in a chain of 1024 pixel cells; a new pixel enters at
// cell width-1 and the above pixel leaves cell 0, so the chain depth is the row.
// Reset and a line width write zero every cell at once; no clearing pass.
// o_stall rises only while a finished result waits under i_stall.
module pixel_gradient_magnitude (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [pgm_pkg::PIXEL_W-1:0]   i_pixel,
    output logic                          o_stall,
    output logic                          o_valid,
    output logic [pgm_pkg::MAG_W-1:0]     o_magnitude,
    input  logic                          i_stall,
    input  logic                          i_cfg_we,
    input  logic [pgm_pkg::LW_W-1:0]      i_cfg_data
);
    import pgm_pkg::*;

    logic [IDX_W-1:0]   r_load_idx;
    logic               accept;
    t_cell_ctrl         ctrl;
    logic [PIXEL_W-1:0] cell_q [MAX_WIDTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_idx <= load_index(LINE_WIDTH_RESET);
        end else if (i_cfg_we) begin
            r_load_idx <= load_index(i_cfg_data);
        end
    end

    assign ctrl.shift = accept;
    assign ctrl.clear = i_cfg_we;

    for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
        logic [PIXEL_W-1:0] next_q;
        if (k == MAX_WIDTH - 1) begin : g_end
            assign next_q = '0;
        end else begin : g_mid
            assign next_q = cell_q[k+1];
        end
        pgm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl),
            .i_load  (r_load_idx == IDX_W'(k)),
            .i_pixel (i_pixel),
            .i_next  (next_q),
            .o_data  (cell_q[k])
        );
    end

    pgm_grad u_grad (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_pixel     (i_pixel),
        .i_above     (cell_q[0]),
        .i_stall     (i_stall),
        .o_stall     (o_stall),
        .o_accept    (accept),
        .o_valid     (o_valid),
        .o_magnitude (o_magnitude)
    );

endmodule

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pgm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic [PIXEL_W-1:0] i_pixel     = '0;
    logic               i_stall     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [LW_W-1:0]    i_cfg_data  = '0;
    logic               o_stall;
    logic               o_valid;
    logic [MAG_W-1:0]   o_magnitude;

    // predictor state
    logic [PIXEL_W-1:0] row_above [MAX_WIDTH];
    logic [PIXEL_W-1:0] last_vdiff;
    logic [SUM_W-1:0]   last_sum;
    logic [IDX_W-1:0]   col_idx;
    logic [LW_W-1:0]    cur_width;

    logic [MAG_W-1:0]   expected_magnitudes [$];
    logic [MAG_W-1:0]   expected_mag;
    int                 mismatch_count = 0;
    int                 idle_cycles    = 0;

    // pacing controls
    bit tx_pace = 1'b0;
    bit rx_pace = 1'b0;
    int burst_left = 0;
    int rx_run = 0;
    bit rx_stall_phase = 1'b0;

    pixel_gradient_magnitude dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_pixel     (i_pixel),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_magnitude (o_magnitude),
        .i_stall     (i_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [MAG_W-1:0] predict_magnitude(input logic [PIXEL_W-1:0] pix);
        int width, col, p, above, vdiff, vert, pix_sum, horiz, blend, mag;
        width = int'(cur_width);
        if (width < 1) width = 1;
        if (width > MAX_WIDTH) width = MAX_WIDTH;
        col = int'(col_idx);
        if (col >= width) col = width - 1;
        p = int'(pix);
        above = int'(row_above[col]);

        vdiff = (above >= p) ? above - p : p - above;
        vert = int'(last_vdiff) + vdiff;
        if (vert > int'(VERT_CLAMP)) vert = int'(VERT_CLAMP);
        last_vdiff = PIXEL_W'(vdiff);

        pix_sum = above + p;
        horiz = (int'(last_sum) >= pix_sum) ? int'(last_sum) - pix_sum : pix_sum - int'(last_sum);
        last_sum = SUM_W'(pix_sum);

        blend = (3 * (vert + horiz)) >> 2;
        mag = vert;
        if (horiz > mag) mag = horiz;
        if (blend > mag) mag = blend;

        row_above[col] = pix;
        col_idx = IDX_W'((col + 1 >= width) ? 0 : col + 1);
        return MAG_W'(mag);
    endfunction

    function automatic logic [PIXEL_W-1:0] next_pixel();
        int sel;
        sel = $urandom_range(0, 7);
        case (sel)
            0: return '0;
            1: return '1;
            default: return PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
        int gap;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_pixel <= pix;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        expected_magnitudes.push_back(predict_magnitude(pix));
        if (tx_pace) begin
            burst_left--;
            if (burst_left <= 0) begin
                gap = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 30);
                @(negedge i_clk);
                i_valid <= 1'b0;
                i_pixel <= PIXEL_W'($urandom);
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic finish_requests();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_magnitudes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_line_width(input logic [LW_W-1:0] width);
        finish_requests();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= width;
        cur_width = width;
        col_idx = '0;
        foreach (row_above[k]) row_above[k] = '0;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_width();
        tx_pace = 1'b0;
        rx_pace = 1'b0;
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd255);
        send_pixel(8'd0);
    endtask

    // width one: every pixel sees the previous one as its row above
    task automatic test_width_one();
        set_line_width(LW_W'(1));
        rx_pace = 1'b1;
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd0);
    endtask

    task automatic test_width_zero();
        set_line_width(LW_W'(0));
        rx_pace = 1'b0;
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(8'd255);
    endtask

    task automatic test_width_two();
        set_line_width(LW_W'(2));
        rx_pace = 1'b1;
        send_pixel(8'd255);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd255);
    endtask

    task automatic test_width_max();
        set_line_width(LW_W'(MAX_WIDTH));
        tx_pace = 1'b0;
        rx_pace = 1'b0;
        repeat (40) send_pixel(next_pixel());
    endtask

    // oversized width must wrap at the full row; run past one row to see it
    task automatic test_width_oversize();
        set_line_width('1);
        for (int i = 0; i < 1100; i++) begin
            tx_pace = (i >= 300);
            rx_pace = (i >= 150);
            send_pixel(next_pixel());
        end
    endtask

    task automatic test_random_widths();
        int width;
        for (int k = 0; k < 10; k++) begin
            width = (k % 4 == 3) ? $urandom_range(41, 1100) : $urandom_range(1, 40);
            set_line_width(LW_W'(width));
            tx_pace = ($urandom_range(0, 3) != 0);
            rx_pace = ($urandom_range(0, 3) != 0);
            repeat (65) send_pixel(next_pixel());
        end
    endtask

    always @(negedge i_clk) begin
        if (!rx_pace) begin
            i_stall <= 1'b0;
        end else begin
            if (rx_run == 0) begin
                rx_stall_phase = !rx_stall_phase;
                rx_run = rx_stall_phase ? $urandom_range(1, 12) : $urandom_range(1, 20);
            end else begin
                rx_run = rx_run - 1;
            end
            i_stall <= rx_stall_phase;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_magnitudes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("tb: result %0d with no request waiting", o_magnitude);
            end else begin
                expected_mag = expected_magnitudes.pop_front();
                if (o_magnitude !== expected_mag) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("tb: magnitude mismatch: expected %0d, got %0d",
                                 expected_mag, o_magnitude);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        foreach (row_above[k]) row_above[k] = '0;
        last_vdiff = '0;
        last_sum   = '0;
        col_idx    = '0;
        cur_width  = LINE_WIDTH_RESET;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_width();
        test_width_one();
        test_width_zero();
        test_width_two();
        test_width_max();
        test_width_oversize();
        test_random_widths();
        finish_requests();

        if (mismatch_count == 0 && expected_magnitudes.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
